FILE: sv/drpc_pkg.sv
// Shared types and constants for the dirty rectangle present copier.
// Used by drpc_clip and dirty_rect_present_copier; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package drpc_pkg;

  // Rectangle list
  localparam int MAX_RECTS = 64;
  localparam int CNT_W     = $clog2(MAX_RECTS + 1);
  localparam int IDX_W     = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECTS);

  // Field widths
  localparam int COORD_W  = 16;
  localparam int DIM_W    = 13;
  localparam int STRIDE_W = 14;
  localparam int SRC_W    = 24;
  localparam int DST_W    = 25;

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DEST_STRIDE   = 2'd2;

  localparam logic [DIM_W-1:0]    SCREEN_WIDTH_RST  = 13'd1024;
  localparam logic [DIM_W-1:0]    SCREEN_HEIGHT_RST = 13'd768;
  localparam logic [STRIDE_W-1:0] DEST_STRIDE_RST   = 14'd1024;

  typedef enum logic [1:0] {
    FUNC_MARK     = 2'd0,
    FUNC_MARK_ALL = 2'd1,
    FUNC_PRESENT  = 2'd2,
    FUNC_TICK     = 2'd3
  } func_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] w;
    logic signed [COORD_W-1:0] h;
  } rect_t;

  // Clipped bounds: columns x0 .. x1-1 and rows y0 .. y1-1.
  typedef struct packed {
    logic [DIM_W-1:0] x0;
    logic [DIM_W-1:0] y0;
    logic [DIM_W-1:0] x1;
    logic [DIM_W-1:0] y1;
  } bounds_t;

  typedef struct packed {
    logic    nonempty;
    bounds_t bounds;
  } clip_t;

endpackage

`default_nettype wire

FILE: sv/drpc_clip.sv
// Clips one stored rectangle against the screen and reports whether anything is left.
// Depends on drpc_pkg for the rectangle and bounds types.
`timescale 1ns / 1ps
`default_nettype none

module drpc_clip (
  input  drpc_pkg::rect_t            rect,
  input  logic [drpc_pkg::DIM_W-1:0] screen_width,
  input  logic [drpc_pkg::DIM_W-1:0] screen_height,
  output drpc_pkg::clip_t            clip
);

  logic signed [drpc_pkg::COORD_W:0] x_lo, x_end, x_hi, sw_s;
  logic signed [drpc_pkg::COORD_W:0] y_lo, y_end, y_hi, sh_s;

  // The far edge of the rectangle does not move when a negative origin is
  // pulled to zero, so it is simply the sum of origin and extent.
  assign x_lo  = rect.x[drpc_pkg::COORD_W-1] ? '0 : {1'b0, rect.x};
  assign y_lo  = rect.y[drpc_pkg::COORD_W-1] ? '0 : {1'b0, rect.y};
  assign x_end = {rect.x[drpc_pkg::COORD_W-1], rect.x} + {rect.w[drpc_pkg::COORD_W-1], rect.w};
  assign y_end = {rect.y[drpc_pkg::COORD_W-1], rect.y} + {rect.h[drpc_pkg::COORD_W-1], rect.h};
  assign sw_s  = {{(drpc_pkg::COORD_W + 1 - drpc_pkg::DIM_W){1'b0}}, screen_width};
  assign sh_s  = {{(drpc_pkg::COORD_W + 1 - drpc_pkg::DIM_W){1'b0}}, screen_height};
  assign x_hi  = (x_end > sw_s) ? sw_s : x_end;
  assign y_hi  = (y_end > sh_s) ? sh_s : y_end;

  always_comb begin
    clip.nonempty  = (x_hi > x_lo) && (y_hi > y_lo);
    clip.bounds.x0 = x_lo[drpc_pkg::DIM_W-1:0];
    clip.bounds.y0 = y_lo[drpc_pkg::DIM_W-1:0];
    clip.bounds.x1 = x_hi[drpc_pkg::DIM_W-1:0];
    clip.bounds.y1 = y_hi[drpc_pkg::DIM_W-1:0];
  end

endmodule

`default_nettype wire

FILE: sv/dirty_rect_present_copier.sv
// Dirty rectangle present copier: rectangle list in a single-port-write RAM, walk sequencer.
// Depends on drpc_pkg and drpc_clip.
// A tick inside a loaded rectangle passes through the emit and output states; the output state
// registers the result and waits while the copy channel stalls. Loading a rectangle, and the
// look-ahead after a rectangle's last pixel, examine list entries one at a time (RAM read, then
// clip check); a scan that runs off the end of the list stops in the RAM read state.
// Reset is synchronous: control state clears, registers return to their defaults, RAM is left.
`timescale 1ns / 1ps
`default_nettype none

module dirty_rect_present_copier (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [drpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [drpc_pkg::DATA_W-1:0]   pwdata,
  output logic [drpc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    func,
  input  logic signed [drpc_pkg::COORD_W-1:0] rect_x,
  input  logic signed [drpc_pkg::COORD_W-1:0] rect_y,
  input  logic signed [drpc_pkg::COORD_W-1:0] rect_w,
  input  logic signed [drpc_pkg::COORD_W-1:0] rect_h,
  // copy channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [drpc_pkg::SRC_W-1:0]    src_index,
  output logic [drpc_pkg::DST_W-1:0]    dst_index,
  output logic                          last_of_present
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_RD,
    S_LOAD_CK,
    S_EMIT,
    S_LOOK_RD,
    S_LOOK_CK,
    S_OUT
  } state_t;

  state_t state;

  logic [drpc_pkg::DIM_W-1:0]    screen_width, screen_height;
  logic [drpc_pkg::STRIDE_W-1:0] dest_stride;

  logic [drpc_pkg::CNT_W-1:0] rect_count, rect_cursor, scan_idx;
  logic                       walking, rect_loaded;
  logic [drpc_pkg::DIM_W-1:0] pixel_col, pixel_row;
  drpc_pkg::bounds_t          clip_bounds;

  logic [drpc_pkg::SRC_W-1:0] res_src;
  logic [drpc_pkg::DST_W-1:0] res_dst;
  logic                       res_last;

  logic accept, out_take, out_free, cfg_write;

  // Rectangle list RAM
  drpc_pkg::rect_t            mem [drpc_pkg::MAX_RECTS];
  logic                       mem_we;
  logic [drpc_pkg::IDX_W-1:0] mem_waddr, mem_raddr;
  drpc_pkg::rect_t            mem_wdata, mem_rdata;
  drpc_pkg::clip_t            clip;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= drpc_pkg::SCREEN_WIDTH_RST;
      screen_height <= drpc_pkg::SCREEN_HEIGHT_RST;
      dest_stride   <= drpc_pkg::DEST_STRIDE_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        drpc_pkg::REG_SCREEN_WIDTH:  screen_width  <= pwdata[drpc_pkg::DIM_W-1:0];
        drpc_pkg::REG_SCREEN_HEIGHT: screen_height <= pwdata[drpc_pkg::DIM_W-1:0];
        drpc_pkg::REG_DEST_STRIDE:   dest_stride   <= pwdata[drpc_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      drpc_pkg::REG_SCREEN_WIDTH:  prdata = drpc_pkg::DATA_W'(screen_width);
      drpc_pkg::REG_SCREEN_HEIGHT: prdata = drpc_pkg::DATA_W'(screen_height);
      drpc_pkg::REG_DEST_STRIDE:   prdata = drpc_pkg::DATA_W'(dest_stride);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshakes
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;

  // ---------------------------------------------------------------- list RAM
  // Writes only happen in the idle state and every read whose data is used is issued in
  // a later read state, so a used read never overlaps a write to the same entry.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rect_count[drpc_pkg::IDX_W-1:0];
    mem_wdata = '{x: rect_x, y: rect_y, w: rect_w, h: rect_h};
    if (accept && !walking) begin
      case (drpc_pkg::func_t'(func))
        drpc_pkg::FUNC_MARK: mem_we = (rect_count < drpc_pkg::MAX_CNT);
        drpc_pkg::FUNC_MARK_ALL: begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = '{x: '0, y: '0,
                        w: drpc_pkg::COORD_W'(screen_width),
                        h: drpc_pkg::COORD_W'(screen_height)};
        end
        default: ;
      endcase
    end
  end

  assign mem_raddr = scan_idx[drpc_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  drpc_clip u_clip (
    .rect          (mem_rdata),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .clip          (clip)
  );

  // ---------------------------------------------------------------- index maths
  logic [2*drpc_pkg::DIM_W-1:0]                  src_prod;
  logic [drpc_pkg::DIM_W+drpc_pkg::STRIDE_W-1:0] dst_prod;
  logic [drpc_pkg::SRC_W-1:0]                    src_calc;
  logic [drpc_pkg::DST_W-1:0]                    dst_calc;
  logic [drpc_pkg::DIM_W:0]                      col_inc, row_inc;

  assign src_prod = {{drpc_pkg::DIM_W{1'b0}}, pixel_row}
                  * {{drpc_pkg::DIM_W{1'b0}}, screen_width};
  assign dst_prod = {{drpc_pkg::STRIDE_W{1'b0}}, pixel_row}
                  * {{drpc_pkg::DIM_W{1'b0}}, dest_stride};
  assign src_calc = src_prod[drpc_pkg::SRC_W-1:0] + drpc_pkg::SRC_W'(pixel_col);
  assign dst_calc = dst_prod[drpc_pkg::DST_W-1:0] + drpc_pkg::DST_W'(pixel_col);
  assign col_inc  = {1'b0, pixel_col} + 1'b1;
  assign row_inc  = {1'b0, pixel_row} + 1'b1;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rect_count  <= '0;
      rect_cursor <= '0;
      scan_idx    <= '0;
      walking     <= 1'b0;
      rect_loaded <= 1'b0;
      pixel_col   <= '0;
      pixel_row   <= '0;
      clip_bounds <= '0;
      out_valid   <= 1'b0;
    end else begin
      // In the output state the register is refilled below instead.
      if (out_take && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (drpc_pkg::func_t'(func) == drpc_pkg::FUNC_TICK) begin
              if (walking) begin
                if (rect_loaded) begin
                  state <= S_EMIT;
                end else begin
                  scan_idx <= rect_cursor;
                  state    <= S_LOAD_RD;
                end
              end
            end else if (!walking) begin
              case (drpc_pkg::func_t'(func))
                drpc_pkg::FUNC_MARK: begin
                  if (rect_count < drpc_pkg::MAX_CNT) begin
                    rect_count <= rect_count + 1'b1;
                  end
                end
                drpc_pkg::FUNC_MARK_ALL: rect_count <= drpc_pkg::CNT_W'(1);
                drpc_pkg::FUNC_PRESENT: begin
                  if (rect_count != '0) begin
                    walking     <= 1'b1;
                    rect_cursor <= '0;
                    rect_loaded <= 1'b0;
                  end
                end
                default: ;
              endcase
            end
          end
        end

        S_LOAD_RD: begin
          if (scan_idx >= rect_count) begin
            // Every remaining rectangle clipped to nothing: the walk ends quietly.
            walking     <= 1'b0;
            rect_loaded <= 1'b0;
            rect_count  <= '0;
            rect_cursor <= '0;
            state       <= S_IDLE;
          end else begin
            state <= S_LOAD_CK;
          end
        end

        S_LOAD_CK: begin
          if (clip.nonempty) begin
            rect_cursor <= scan_idx;
            clip_bounds <= clip.bounds;
            pixel_col   <= clip.bounds.x0;
            pixel_row   <= clip.bounds.y0;
            rect_loaded <= 1'b1;
            state       <= S_EMIT;
          end else begin
            scan_idx <= scan_idx + 1'b1;
            state    <= S_LOAD_RD;
          end
        end

        S_EMIT: begin
          res_src  <= src_calc;
          res_dst  <= dst_calc;
          res_last <= 1'b0;
          if (col_inc >= {1'b0, clip_bounds.x1}) begin
            pixel_col <= clip_bounds.x0;
            pixel_row <= row_inc[drpc_pkg::DIM_W-1:0];
            if (row_inc >= {1'b0, clip_bounds.y1}) begin
              // Rectangle finished: look ahead for any later one with pixels left.
              rect_loaded <= 1'b0;
              rect_cursor <= rect_cursor + 1'b1;
              scan_idx    <= rect_cursor + 1'b1;
              state       <= S_LOOK_RD;
            end else begin
              state <= S_OUT;
            end
          end else begin
            pixel_col <= col_inc[drpc_pkg::DIM_W-1:0];
            state     <= S_OUT;
          end
        end

        S_LOOK_RD: begin
          if (scan_idx >= rect_count) begin
            res_last    <= 1'b1;
            walking     <= 1'b0;
            rect_loaded <= 1'b0;
            rect_count  <= '0;
            rect_cursor <= '0;
            state       <= S_OUT;
          end else begin
            state <= S_LOOK_CK;
          end
        end

        S_LOOK_CK: begin
          if (clip.nonempty) begin
            state <= S_OUT;
          end else begin
            scan_idx <= scan_idx + 1'b1;
            state    <= S_LOOK_RD;
          end
        end

        S_OUT: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            src_index       <= res_src;
            dst_index       <= res_dst;
            last_of_present <= res_last;
            state           <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
